// ----- hw/rtl/scan_disk_scheduler_core_defines.svh -----
// assertion macros for the scan disk scheduler checker
`ifndef SCAN_DISK_SCHEDULER_CORE_DEFINES_SVH
`define SCAN_DISK_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sds check failed");

// next-cycle implication, sampled on clk, off during rst
`define SDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sds check failed");

`endif

// ----- hw/rtl/sds_pkg.sv -----
// shared types and codes for the scan disk scheduler
package sds_pkg;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // configuration register indexes
  localparam logic CFG_DISK_TRACKS = 1'b0;
  localparam logic CFG_SWEEP_UP    = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] track;
  } sds_in_t;

  typedef struct packed {
    logic [15:0] visit_track;
    logic [31:0] seek_total;
    logic        last;
  } sds_out_t;

  // one emitted track from the sequencer to the output stage
  typedef struct packed {
    logic        en;
    logic        first;
    logic [15:0] trk;
    logic        last;
  } sds_emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SEL1,
    ST_BOUND,
    ST_SEL2
  } sds_state_t;

endpackage

// ----- hw/rtl/sds_seek_acc.sv -----
// output word register with running saturating seek distance
module sds_seek_acc (
  input  logic              clk,
  input  logic              rst,
  input  sds_pkg::sds_emit_t emit,
  output sds_pkg::sds_out_t  result,
  output logic              strobe
);
  import sds_pkg::*;

  logic [15:0] delta;
  logic [32:0] sum;

  // distance from the track shown last, and the grown total
  always_comb begin
    if (emit.trk >= result.visit_track) begin
      delta = emit.trk - result.visit_track;
    end else begin
      delta = result.visit_track - emit.trk;
    end
    sum = {1'b0, result.seek_total} + {17'b0, delta};
  end

  // strobe is control, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit.en;
    end
  end

  // the result register also holds the head position and the total
  always_ff @(posedge clk) begin
    if (emit.en) begin
      result.visit_track <= emit.trk;
      result.last        <= emit.last;
      if (emit.first) begin
        result.seek_total <= 32'd0;
      end else if (sum[32]) begin
        result.seek_total <= 32'hFFFF_FFFF;
      end else begin
        result.seek_total <= sum[31:0];
      end
    end
  end

endmodule

// ----- hw/rtl/scan_disk_scheduler_core.sv -----
// top level of the scan (elevator) disk scheduler
// A load word (command 0) writes one request track into the store and leaves busy low;
// loads past MAX_REQUESTS are dropped. A run word (command 1) raises busy and emits the
// head, the requests of the first sweep, the disk end (or track 0), then the requests of
// the return sweep, each as a one-cycle strobe with no way to hold it off. The store is
// one single-port memory, so every emitted request costs one full pass over it. The head
// result appears in the cycle after the run word, and the last result shows in the first
// cycle that busy is low again. The store is empty again once last is shown.
module scan_disk_scheduler_core #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sds_pkg::sds_in_t item,
  output sds_pkg::sds_out_t result,
  output logic             strobe,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [16:0]      cfg_data
);
  import sds_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int KW = 16 + IW;

  // configuration
  logic [16:0] disk_tracks;
  logic        sweep_up;

  // request store
  logic [15:0] mem [MAX_REQUESTS];
  logic [15:0] rd_data;
  logic [CW-1:0] count;

  // sequencer state
  sds_state_t state, state_next;
  logic [15:0]   head;
  logic [CW-1:0] rd_ptr;
  logic          cmp_v;
  logic [IW-1:0] cmp_idx;
  logic          best_v;
  logic [KW-1:0] best_key;
  logic          prev_v;
  logic [KW-1:0] prev_key;
  logic [CW-1:0] nu;
  logic [CW-1:0] k;
  logic [CW-1:0] k2;

  // control
  logic          load_acc, run_acc;
  logic          scan_state, issue, scan_done;
  logic          asc, is_up, eligible, better;
  logic [KW-1:0] key;
  logic [CW-1:0] nl, k1, k2v;
  logic [15:0]   end_trk, boundary;
  logic          restart, finish;
  sds_emit_t     emit;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign load_acc  = start && !busy && (item.command == CMD_LOAD);
  assign run_acc   = start && !busy && (item.command == CMD_RUN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_tracks <= 17'h10000;
      sweep_up    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DISK_TRACKS: disk_tracks <= cfg_data;
        CFG_SWEEP_UP:    sweep_up    <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // disk end with the track count clamped to 1..65536
  always_comb begin
    priority if (disk_tracks == 17'd0) begin
      end_trk = 16'd0;
    end else if (disk_tracks[16]) begin
      end_trk = 16'hFFFF;
    end else begin
      end_trk = disk_tracks[15:0] - 16'd1;
    end
    boundary = sweep_up ? end_trk : 16'd0;
  end

  // store write on load, read one entry per cycle during a pass
  always_ff @(posedge clk) begin
    if (load_acc && (count < CW'(MAX_REQUESTS))) begin
      mem[count[IW-1:0]] <= item.track;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr[IW-1:0]];
    end
  end

  // pass control and candidate compare; keys tie-break on store index
  always_comb begin
    scan_state = (state == ST_COUNT) || (state == ST_SEL1) || (state == ST_SEL2);
    issue      = scan_state && (rd_ptr != count);
    scan_done  = scan_state && !cmp_v && (rd_ptr == count);
    asc        = (state == ST_SEL1) ? sweep_up : !sweep_up;
    key        = {rd_data, cmp_idx};
    is_up      = (rd_data >= head);
    if (asc) begin
      eligible = is_up && (!prev_v || (key > prev_key));
      better   = !best_v || (key < best_key);
    end else begin
      eligible = !is_up && (!prev_v || (key < prev_key));
      better   = !best_v || (key > best_key);
    end
    nl  = count - nu;
    k1  = sweep_up ? nu : nl;
    k2v = sweep_up ? nl : nu;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and emitted words
  always_comb begin
    state_next = state;
    restart    = 1'b0;
    finish     = 1'b0;
    emit       = '0;
    unique case (state)
      ST_IDLE: begin
        if (run_acc) begin
          emit       = '{en: 1'b1, first: 1'b1, trk: item.track, last: 1'b0};
          restart    = 1'b1;
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (scan_done) begin
          restart    = 1'b1;
          state_next = (k1 != '0) ? ST_SEL1 : ST_BOUND;
        end
      end
      ST_SEL1: begin
        if (scan_done) begin
          emit    = '{en: 1'b1, first: 1'b0, trk: best_key[KW-1:IW], last: 1'b0};
          restart = 1'b1;
          if (k == CW'(1)) begin
            state_next = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        emit    = '{en: 1'b1, first: 1'b0, trk: boundary, last: (k2 == '0)};
        restart = 1'b1;
        if (k2 != '0) begin
          state_next = ST_SEL2;
        end else begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SEL2: begin
        if (scan_done) begin
          emit    = '{en: 1'b1, first: 1'b0, trk: best_key[KW-1:IW], last: (k == CW'(1))};
          restart = 1'b1;
          if (k == CW'(1)) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (finish) begin
      count <= '0;
    end else if (load_acc && (count < CW'(MAX_REQUESTS))) begin
      count <= count + CW'(1);
    end
  end

  // pass pointers and best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      cmp_v  <= 1'b0;
      best_v <= 1'b0;
    end else if (restart) begin
      rd_ptr <= '0;
      cmp_v  <= 1'b0;
      best_v <= 1'b0;
    end else begin
      if (issue) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      cmp_v <= issue;
      if (cmp_v && (state != ST_COUNT) && eligible && better) begin
        best_v <= 1'b1;
      end
    end
  end

  // sweep bookkeeping
  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_ptr[IW-1:0];
    end
    if (cmp_v && (state != ST_COUNT) && eligible && better) begin
      best_key <= key;
    end
    if (run_acc) begin
      head <= item.track;
      nu   <= '0;
    end else if ((state == ST_COUNT) && cmp_v && is_up) begin
      nu <= nu + CW'(1);
    end
    unique case (state)
      ST_COUNT: begin
        if (scan_done) begin
          k      <= k1;
          k2     <= k2v;
          prev_v <= 1'b0;
        end
      end
      ST_SEL1, ST_SEL2: begin
        if (scan_done) begin
          k        <= k - CW'(1);
          prev_key <= best_key;
          prev_v   <= 1'b1;
        end
      end
      ST_BOUND: begin
        k      <= k2;
        prev_v <= 1'b0;
      end
      default: ;
    endcase
  end

  // output stage
  sds_seek_acc u_seek (
    .clk    (clk),
    .rst    (rst),
    .emit   (emit),
    .result (result),
    .strobe (strobe)
  );

endmodule

// ----- hw/rtl/sds_checker.sv -----
// port-level checks for the scan disk scheduler, bound to the top level
`include "scan_disk_scheduler_core_defines.svh"

module sds_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input sds_pkg::sds_in_t  item,
  input sds_pkg::sds_out_t result,
  input logic              strobe
);
  import sds_pkg::*;

  // a run answers at once with the head at zero distance
  `SDS_ASSERT_NEXT(a_head_first, start && !busy && (item.command == CMD_RUN), strobe && (result.seek_total == 32'd0) && (result.visit_track == $past(item.track)) && !result.last)

  // a load never produces a word
  `SDS_ASSERT_NEXT(a_load_silent, start && !busy && (item.command == CMD_LOAD), !strobe)

  // only the final word of a run finds the block idle
  `SDS_ASSERT_NOW(a_last_idle, strobe, busy == !result.last)

endmodule

bind scan_disk_scheduler_core sds_checker u_sds_checker (.*);
